// ===== hw/rtl/ebcpu_pkg.sv =====
`timescale 1ns / 1ps
package ebcpu_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
        OP_EOR = 6'd4,  OP_ASL = 6'd5,  OP_LSR = 6'd6,  OP_ROL = 6'd7,
        OP_ROR = 6'd8,  OP_INC = 6'd9,  OP_DEC = 6'd10, OP_INX = 6'd11,
        OP_INY = 6'd12, OP_DEX = 6'd13, OP_DEY = 6'd14, OP_CMP = 6'd15,
        OP_CPX = 6'd16, OP_CPY = 6'd17, OP_BIT = 6'd18, OP_LDA = 6'd19,
        OP_LDX = 6'd20, OP_LDY = 6'd21, OP_TAX = 6'd22, OP_TAY = 6'd23,
        OP_TXA = 6'd24, OP_TYA = 6'd25, OP_TSX = 6'd26, OP_TXS = 6'd27,
        OP_CLC = 6'd28, OP_SEC = 6'd29, OP_CLI = 6'd30, OP_SEI = 6'd31,
        OP_CLD = 6'd32, OP_SED = 6'd33, OP_CLV = 6'd34, OP_BCC = 6'd35,
        OP_BCS = 6'd36, OP_BEQ = 6'd37, OP_BNE = 6'd38, OP_BMI = 6'd39,
        OP_BPL = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42, OP_JMP = 6'd43,
        OP_STA = 6'd44, OP_STX = 6'd45, OP_STY = 6'd46, OP_BRK = 6'd47
    } op_t;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] SP_RESET = 8'hFF;

    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  operand;
        logic        on_acc;
        logic [15:0] addr;
        logic [15:0] npc;
        logic [15:0] branch_pc;
        logic        is_write_rmw;
    } item_t;

    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [15:0] pc;
    } result_t;

endpackage

// ===== hw/rtl/ebcpu_front.sv =====
`timescale 1ns / 1ps
module ebcpu_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [5:0]           op,
    input  logic [7:0]           operand,
    input  logic                 on_acc,
    input  logic [15:0]          addr,
    input  logic [15:0]          npc,
    output logic                 q_valid,
    input  logic                 q_ready,
    output ebcpu_pkg::item_t     q_item
);

    ebcpu_pkg::item_t item0_reg, item1_reg;
    logic [1:0]       cnt_reg;
    ebcpu_pkg::item_t cls;
    logic             push, pop;

    always_comb
    begin
        cls.op           = op;
        cls.operand      = operand;
        cls.on_acc       = on_acc;
        cls.addr         = addr;
        cls.npc          = npc;
        cls.branch_pc    = npc + {{8{operand[7]}}, operand};
        cls.is_write_rmw = ((op >= 6'(ebcpu_pkg::OP_ASL)) && (op <= 6'(ebcpu_pkg::OP_ROR))
                            && !on_acc) || (op == 6'(ebcpu_pkg::OP_INC))
                            || (op == 6'(ebcpu_pkg::OP_DEC))
                            || (op == 6'(ebcpu_pkg::OP_STA))
                            || (op == 6'(ebcpu_pkg::OP_STX))
                            || (op == 6'(ebcpu_pkg::OP_STY));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = item0_reg;
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item0_reg <= (cnt_reg == 2'd2) ? item1_reg : cls;
        end
        else if (push && cnt_reg == 2'd0)
        begin
            item0_reg <= cls;
        end
        if (push && ((cnt_reg == 2'd1 && !pop) || (cnt_reg == 2'd2)))
        begin
            item1_reg <= cls;
        end
    end

endmodule

// ===== hw/rtl/ebcpu_back.sv =====
`timescale 1ns / 1ps
module ebcpu_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ebcpu_pkg::item_t     q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ebcpu_pkg::result_t   out_res
);

    logic [7:0]  a_reg, x_reg, y_reg, sp_reg, f_reg;
    logic [15:0] bv_reg;
    logic        ov_reg;
    ebcpu_pkg::result_t res_reg;

    logic [7:0]  a_n, x_n, y_n, sp_n, f_n, v, wd, sh_in, sh_r, nz_v, cmp_src;
    logic [15:0] pc_n;
    logic [8:0]  sum, cmp_d;
    logic        nz_en, taken, fire;

    assign q_ready   = !ov_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        v     = q_item.operand;
        a_n   = a_reg;
        x_n   = x_reg;
        y_n   = y_reg;
        sp_n  = sp_reg;
        f_n   = f_reg;
        pc_n  = q_item.npc;
        wd    = 8'd0;
        nz_en = 1'b0;
        nz_v  = 8'd0;
        taken = 1'b0;
        sum   = 9'd0;
        sh_in = q_item.on_acc ? a_reg : v;
        sh_r  = 8'd0;
        cmp_src = (q_item.op == 6'(ebcpu_pkg::OP_CPX)) ? x_reg :
                  (q_item.op == 6'(ebcpu_pkg::OP_CPY)) ? y_reg : a_reg;
        cmp_d = {1'b0, cmp_src} - {1'b0, v};
        unique case (q_item.op)
            6'(ebcpu_pkg::OP_ADC), 6'(ebcpu_pkg::OP_SBC):
            begin
                if (q_item.op == 6'(ebcpu_pkg::OP_SBC))
                begin
                    v = ~v;
                end
                sum = {1'b0, a_reg} + {1'b0, v} + {8'd0, f_reg[ebcpu_pkg::FL_C]};
                f_n[ebcpu_pkg::FL_C] = sum[8];
                f_n[ebcpu_pkg::FL_V] = ~(a_reg[7] ^ v[7]) & (a_reg[7] ^ sum[7]);
                a_n = sum[7:0];
                nz_en = 1'b1;
                nz_v = sum[7:0];
            end
            6'(ebcpu_pkg::OP_AND): begin a_n = a_reg & v; nz_en = 1'b1; nz_v = a_n; end
            6'(ebcpu_pkg::OP_ORA): begin a_n = a_reg | v; nz_en = 1'b1; nz_v = a_n; end
            6'(ebcpu_pkg::OP_EOR): begin a_n = a_reg ^ v; nz_en = 1'b1; nz_v = a_n; end
            6'(ebcpu_pkg::OP_ASL), 6'(ebcpu_pkg::OP_LSR),
            6'(ebcpu_pkg::OP_ROL), 6'(ebcpu_pkg::OP_ROR):
            begin
                unique case (q_item.op)
                    6'(ebcpu_pkg::OP_ASL): sh_r = {sh_in[6:0], 1'b0};
                    6'(ebcpu_pkg::OP_LSR): sh_r = {1'b0, sh_in[7:1]};
                    6'(ebcpu_pkg::OP_ROL): sh_r = {sh_in[6:0], f_reg[ebcpu_pkg::FL_C]};
                    default:               sh_r = {f_reg[ebcpu_pkg::FL_C], sh_in[7:1]};
                endcase
                f_n[ebcpu_pkg::FL_C] = ((q_item.op == 6'(ebcpu_pkg::OP_ASL)) ||
                                        (q_item.op == 6'(ebcpu_pkg::OP_ROL)))
                                       ? sh_in[7] : sh_in[0];
                if (q_item.on_acc)
                begin
                    a_n = sh_r;
                end
                else
                begin
                    wd = sh_r;
                end
                nz_en = 1'b1;
                nz_v = sh_r;
            end
            6'(ebcpu_pkg::OP_INC): begin wd = v + 8'd1; nz_en = 1'b1; nz_v = wd; end
            6'(ebcpu_pkg::OP_DEC): begin wd = v - 8'd1; nz_en = 1'b1; nz_v = wd; end
            6'(ebcpu_pkg::OP_INX): begin x_n = x_reg + 8'd1; nz_en = 1'b1; nz_v = x_n; end
            6'(ebcpu_pkg::OP_INY): begin y_n = y_reg + 8'd1; nz_en = 1'b1; nz_v = y_n; end
            6'(ebcpu_pkg::OP_DEX): begin x_n = x_reg - 8'd1; nz_en = 1'b1; nz_v = x_n; end
            6'(ebcpu_pkg::OP_DEY): begin y_n = y_reg - 8'd1; nz_en = 1'b1; nz_v = y_n; end
            6'(ebcpu_pkg::OP_CMP), 6'(ebcpu_pkg::OP_CPX), 6'(ebcpu_pkg::OP_CPY):
            begin
                f_n[ebcpu_pkg::FL_C] = ~cmp_d[8];
                nz_en = 1'b1;
                nz_v = cmp_d[7:0];
            end
            6'(ebcpu_pkg::OP_BIT):
            begin
                f_n[ebcpu_pkg::FL_Z] = ((a_reg & v) == 8'd0);
                f_n[ebcpu_pkg::FL_N] = v[7];
                f_n[ebcpu_pkg::FL_V] = v[6];
            end
            6'(ebcpu_pkg::OP_LDA): begin a_n = v; nz_en = 1'b1; nz_v = v; end
            6'(ebcpu_pkg::OP_LDX): begin x_n = v; nz_en = 1'b1; nz_v = v; end
            6'(ebcpu_pkg::OP_LDY): begin y_n = v; nz_en = 1'b1; nz_v = v; end
            6'(ebcpu_pkg::OP_TAX): begin x_n = a_reg; nz_en = 1'b1; nz_v = a_reg; end
            6'(ebcpu_pkg::OP_TAY): begin y_n = a_reg; nz_en = 1'b1; nz_v = a_reg; end
            6'(ebcpu_pkg::OP_TXA): begin a_n = x_reg; nz_en = 1'b1; nz_v = x_reg; end
            6'(ebcpu_pkg::OP_TYA): begin a_n = y_reg; nz_en = 1'b1; nz_v = y_reg; end
            6'(ebcpu_pkg::OP_TSX): begin x_n = sp_reg; nz_en = 1'b1; nz_v = sp_reg; end
            6'(ebcpu_pkg::OP_TXS): sp_n = x_reg;
            6'(ebcpu_pkg::OP_CLC): f_n[ebcpu_pkg::FL_C] = 1'b0;
            6'(ebcpu_pkg::OP_SEC): f_n[ebcpu_pkg::FL_C] = 1'b1;
            6'(ebcpu_pkg::OP_CLI): f_n[ebcpu_pkg::FL_I] = 1'b0;
            6'(ebcpu_pkg::OP_SEI): f_n[ebcpu_pkg::FL_I] = 1'b1;
            6'(ebcpu_pkg::OP_CLD): f_n[ebcpu_pkg::FL_D] = 1'b0;
            6'(ebcpu_pkg::OP_SED): f_n[ebcpu_pkg::FL_D] = 1'b1;
            6'(ebcpu_pkg::OP_CLV): f_n[ebcpu_pkg::FL_V] = 1'b0;
            6'(ebcpu_pkg::OP_BCC): taken = !f_reg[ebcpu_pkg::FL_C];
            6'(ebcpu_pkg::OP_BCS): taken = f_reg[ebcpu_pkg::FL_C];
            6'(ebcpu_pkg::OP_BEQ): taken = f_reg[ebcpu_pkg::FL_Z];
            6'(ebcpu_pkg::OP_BNE): taken = !f_reg[ebcpu_pkg::FL_Z];
            6'(ebcpu_pkg::OP_BMI): taken = f_reg[ebcpu_pkg::FL_N];
            6'(ebcpu_pkg::OP_BPL): taken = !f_reg[ebcpu_pkg::FL_N];
            6'(ebcpu_pkg::OP_BVC): taken = !f_reg[ebcpu_pkg::FL_V];
            6'(ebcpu_pkg::OP_BVS): taken = f_reg[ebcpu_pkg::FL_V];
            6'(ebcpu_pkg::OP_JMP): pc_n = q_item.addr;
            6'(ebcpu_pkg::OP_STA): wd = a_reg;
            6'(ebcpu_pkg::OP_STX): wd = x_reg;
            6'(ebcpu_pkg::OP_STY): wd = y_reg;
            6'(ebcpu_pkg::OP_BRK):
            begin
                f_n[ebcpu_pkg::FL_B] = 1'b1;
                pc_n = bv_reg;
            end
            default: ;
        endcase
        if (nz_en)
        begin
            f_n[ebcpu_pkg::FL_Z] = (nz_v == 8'd0);
            f_n[ebcpu_pkg::FL_N] = nz_v[7];
        end
        if (taken)
        begin
            pc_n = q_item.branch_pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= 8'd0;
            x_reg  <= 8'd0;
            y_reg  <= 8'd0;
            sp_reg <= ebcpu_pkg::SP_RESET;
            f_reg  <= 8'd0;
            bv_reg <= 16'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bv_reg <= cfg_data;
            end
            if (fire)
            begin
                a_reg  <= a_n;
                x_reg  <= x_n;
                y_reg  <= y_n;
                sp_reg <= sp_n;
                f_reg  <= f_n;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg.mem_write   <= q_item.is_write_rmw;
            res_reg.mem_address <= q_item.is_write_rmw ? q_item.addr : 16'd0;
            res_reg.mem_data    <= q_item.is_write_rmw ? wd : 8'd0;
            res_reg.acc         <= a_n;
            res_reg.x           <= x_n;
            res_reg.y           <= y_n;
            res_reg.sp          <= sp_n;
            res_reg.flags       <= f_n;
            res_reg.pc          <= pc_n;
        end
    end

endmodule

// ===== hw/rtl/eight_bit_cpu_execute_unit.sv =====
`timescale 1ns / 1ps
// Execute unit for decoded 8-bit processor operations, one result item per input item.
// The slave stream carries the decoded operation; tuser holds req_type and tdata holds
// operand, on_accumulator, target_address and next_pc.
// The master stream returns the memory write and the whole register file after the
// operation; tuser holds mem_write and tdata holds the other result fields.
// A front stage classifies each item and works out the branch target, then places it in a
// two-entry queue. The back stage executes one item per cycle against the register file
// while the receiver does not stall, and holds the result in an output register.
// When nothing stalls, an accepted item is written into the queue, then executed by the back
// stage into the output register, which raises m_tvalid; the sustained rate is one item per
// cycle.
// A stalled receiver holds the output register; the queue then fills and s_tready falls
// after two further items.
// Reset clears A, X, Y, flags and break vector, and sets the stack pointer to 0xFF.
// The break vector is written through cfg_we and cfg_data.
module eight_bit_cpu_execute_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operand[7:0], on_accumulator[8], target_address[24:9], next_pc[40:25], zero pad
    input  logic [47:0] s_tdata,
    // req_type[5:0]
    input  logic [5:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mem_address[15:0], mem_data[23:16], acc_out[31:24], index_x_out[39:32],
    // index_y_out[47:40], stack_ptr_out[55:48], flags_out[63:56], prog_counter_out[79:64]
    output logic [79:0] m_tdata,
    // mem_write[0]
    output logic        m_tuser
);

    logic               q_valid, q_ready;
    ebcpu_pkg::item_t   q_item;
    ebcpu_pkg::result_t res;

    ebcpu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op       (s_tuser),
        .operand  (s_tdata[7:0]),
        .on_acc   (s_tdata[8]),
        .addr     (s_tdata[24:9]),
        .npc      (s_tdata[40:25]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ebcpu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.mem_write;
    assign m_tdata = {res.pc, res.flags, res.sp, res.y, res.x, res.acc,
                      res.mem_data, res.mem_address};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0)
        else $error("write fields not cleared");

    a_queue_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("front blocked with empty queue");

endmodule
